// ===== hw/rtl/nrr_pkg.sv =====
// Shared types and constants of the note repeat ratchet engine.
package nrr_pkg;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_TRIGGER  = 2'd1;
    localparam logic [1:0] CMD_STOP     = 2'd2;
    localparam logic [1:0] CMD_STOP_ALL = 2'd3;

    localparam logic [2:0] REG_TEMPO  = 3'd0;
    localparam logic [2:0] REG_ENABLE = 3'd1;
    localparam logic [2:0] REG_RATE   = 3'd2;
    localparam logic [2:0] REG_GATE   = 3'd3;
    localparam logic [2:0] REG_DECAY  = 3'd4;
    localparam logic [2:0] REG_ACCENT = 3'd5;

    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [1:0] command;
        logic [2:0] track;
        logic [6:0] note_in;
        logic [6:0] velocity_in;
        logic [3:0] channel_in;
    } req_t;

    typedef struct packed {
        logic [2:0] track_out;
        logic [6:0] note_out;
        logic [6:0] velocity_out;
        logic [3:0] channel_out;
        logic       is_note_on;
        logic       last_event;
    } evt_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DIV3,
        MUL_GATE,
        MUL_G100,
        MUL_CD,
        MUL_CDB,
        MUL_V100,
        MUL_ACC
    } mul_op_t;

    typedef struct packed {
        logic       latch_req;
        logic       tick_start;
        logic       div_step;
        logic [3:0] div_bit;
        logic [2:0] trk;
        mul_op_t    mul_op;
        logic       set_interval;
        logic       set_gtime;
        logic       set_vel;
        logic       set_accent;
        logic       emit_off;
        logic       emit_on;
        logic       cmd_exec;
        logic       flush;
    } nrr_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic live;
        logic off_due;
        logic on_due;
        logic can_push;
        logic pend_valid;
        logic out_free;
    } nrr_sts_t;

endpackage

// ===== hw/rtl/nrr_ctrl.sv =====
// Sequencer that walks commands and tracks and issues datapath steps.
module nrr_ctrl #(
    parameter int TRACKS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  nrr_pkg::nrr_sts_t sts,
    output nrr_pkg::nrr_cmd_t cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_DIV, S_TRK, S_IV1, S_IV2, S_G1, S_G2, S_G3, S_OFF,
        S_ONCHK, S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_ON, S_NEXT, S_CMD, S_FIN
    } state_t;

    state_t     state_reg;
    logic [3:0] cnt_reg;
    logic [2:0] trk_reg;

    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            trk_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    cnt_reg   <= '0;
                    trk_reg   <= '0;
                    state_reg <= sts.is_tick ? S_DIV : S_CMD;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'(nrr_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_TRK;
                    end
                end
                S_TRK:   state_reg <= sts.live ? S_IV1 : S_NEXT;
                S_IV1:   state_reg <= S_IV2;
                S_IV2:   state_reg <= S_G1;
                S_G1:    state_reg <= S_G2;
                S_G2:    state_reg <= S_G3;
                S_G3:    state_reg <= S_OFF;
                S_OFF:
                begin
                    if (!sts.off_due || sts.can_push)
                    begin
                        state_reg <= S_ONCHK;
                    end
                end
                S_ONCHK: state_reg <= sts.on_due ? S_V1 : S_NEXT;
                S_V1:    state_reg <= S_V2;
                S_V2:    state_reg <= S_V3;
                S_V3:    state_reg <= S_V4;
                S_V4:    state_reg <= S_V5;
                S_V5:    state_reg <= S_V6;
                S_V6:    state_reg <= S_ON;
                S_ON:
                begin
                    if (sts.can_push)
                    begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (trk_reg == 3'(TRACKS - 1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        trk_reg   <= trk_reg + 3'd1;
                        state_reg <= S_TRK;
                    end
                end
                S_CMD:   state_reg <= S_FIN;
                S_FIN:
                begin
                    if (!sts.pend_valid || sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd              = '0;
        cmd.mul_op       = nrr_pkg::MUL_NONE;
        cmd.trk          = trk_reg;
        cmd.div_bit      = cnt_reg;
        cmd.latch_req    = (state_reg == S_IDLE) && req_valid;
        cmd.tick_start   = (state_reg == S_DISP) && sts.is_tick;
        cmd.div_step     = (state_reg == S_DIV);
        cmd.set_interval = (state_reg == S_IV2);
        cmd.set_gtime    = (state_reg == S_G3);
        cmd.set_vel      = (state_reg == S_V4);
        cmd.set_accent   = (state_reg == S_V6);
        cmd.emit_off     = (state_reg == S_OFF) && sts.off_due && sts.can_push;
        cmd.emit_on      = (state_reg == S_ON) && sts.can_push;
        cmd.cmd_exec     = (state_reg == S_CMD);
        cmd.flush        = (state_reg == S_FIN) && sts.pend_valid && sts.out_free;
        case (state_reg)
            S_IV1:   cmd.mul_op = nrr_pkg::MUL_DIV3;
            S_G1:    cmd.mul_op = nrr_pkg::MUL_GATE;
            S_G2:    cmd.mul_op = nrr_pkg::MUL_G100;
            S_V1:    cmd.mul_op = nrr_pkg::MUL_CD;
            S_V2:    cmd.mul_op = nrr_pkg::MUL_CDB;
            S_V3:    cmd.mul_op = nrr_pkg::MUL_V100;
            S_V5:    cmd.mul_op = nrr_pkg::MUL_ACC;
            default: cmd.mul_op = nrr_pkg::MUL_NONE;
        endcase
    end

endmodule

// ===== hw/rtl/nrr_dpath.sv =====
// Datapath: registers, track state, shared multiplier, tempo divider, event buffers.
module nrr_dpath #(
    parameter int TRACKS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nrr_pkg::req_t     req,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data,
    output logic              evt_valid,
    input  logic              evt_ready,
    output nrr_pkg::evt_t     evt,
    input  nrr_pkg::nrr_cmd_t cmd,
    output nrr_pkg::nrr_sts_t sts
);

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam logic [19:0] K100 = 20'd671089;  // ceil(2^26 / 100)
    localparam logic [19:0] K3   = 20'd43691;   // ceil(2^17 / 3)
    localparam logic [19:0] K5   = 20'd205;     // ceil(2^10 / 5)
    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    logic [8:0]  tempo_reg;
    logic [7:0]  enable_reg;
    logic [23:0] rate_reg;
    logic [55:0] gate_reg;
    logic [47:0] decay_reg;
    logic [63:0] accent_reg;

    nrr_pkg::req_t req_reg;
    logic [31:0] ms_reg;

    logic        active_reg   [TRACKS];
    logic        sounding_reg [TRACKS];
    logic [6:0]  note_reg     [TRACKS];
    logic [6:0]  base_reg     [TRACKS];
    logic [3:0]  chan_reg     [TRACKS];
    logic [31:0] last_reg     [TRACKS];
    logic [7:0]  count_reg    [TRACKS];

    logic [9:0]  rem_reg;
    logic [15:0] quo_reg;
    logic [40:0] prod_reg;
    logic [11:0] interval_reg;
    logic [14:0] gtime_reg;
    logic [31:0] elapsed_reg;
    logic [6:0]  vel_reg;

    nrr_pkg::evt_t pend_reg;
    logic          pend_valid_reg;
    nrr_pkg::evt_t out_reg;
    logic          out_valid_reg;

    logic [TW-1:0] ti;
    logic [TW-1:0] ri;
    logic          in_range;
    logic [9:0]    rem_shift;
    logic [11:0]   quarter;
    logic [9:0]    six;
    logic [2:0]    rate_code;
    logic [6:0]    gate_raw;
    logic [6:0]    gate_pct;
    logic [5:0]    decay_raw;
    logic [5:0]    decay_pct;
    logic [11:0]   num3;
    logic [11:0]   interval_sel;
    logic [20:0]   mul_a;
    logic [19:0]   mul_b;
    logic [14:0]   amt;
    logic [9:0]    vel6;
    logic [7:0]    vacc;
    logic          acc_hit;
    logic          out_free;
    logic          ev_load;
    nrr_pkg::evt_t ev_data;
    logic          cmd_emit;
    nrr_pkg::evt_t cmd_ev;

    assign ti       = cmd.trk[TW-1:0];
    assign ri       = req_reg.track[TW-1:0];
    assign in_range = ({1'b0, req_reg.track} < 4'(TRACKS));

    assign rem_shift = {rem_reg[8:0], MS_PER_MIN[4'(15) - cmd.div_bit]};
    assign quarter   = quo_reg[11:0];
    assign six       = quarter[11:2];

    assign rate_code = rate_reg[cmd.trk * 3 +: 3];
    assign gate_raw  = gate_reg[cmd.trk * 7 +: 7];
    assign decay_raw = decay_reg[cmd.trk * 6 +: 6];
    assign gate_pct  = (gate_raw < 7'd10) ? 7'd10 : ((gate_raw > 7'd95) ? 7'd95 : gate_raw);
    assign decay_pct = (decay_raw > 6'd50) ? 6'd50 : decay_raw;

    always_comb
    begin
        case (rate_code)
            3'd5:    num3 = {six, 2'b00};
            3'd6:    num3 = {1'b0, six, 1'b0};
            default: num3 = {2'b00, six};
        endcase
        case (rate_code)
            3'd0:    interval_sel = quarter;
            3'd1:    interval_sel = {1'b0, six, 1'b0};
            3'd2:    interval_sel = {2'b00, six};
            3'd3:    interval_sel = {3'b000, six[9:1]};
            3'd4:    interval_sel = {4'b0000, six[9:2]};
            default: interval_sel = prod_reg[28:17];
        endcase
    end

    assign amt     = prod_reg[40:26];
    assign vel6    = {1'b0, vel_reg, 2'b00} + {2'b00, vel_reg, 1'b0};
    assign vacc    = prod_reg[17:10];
    assign acc_hit = accent_reg[{cmd.trk, count_reg[ti][2:0]}];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            nrr_pkg::MUL_DIV3:
            begin
                mul_a = 21'(num3);
                mul_b = K3;
            end
            nrr_pkg::MUL_GATE:
            begin
                mul_a = 21'(interval_reg);
                mul_b = 20'(gate_pct);
            end
            nrr_pkg::MUL_G100:
            begin
                mul_a = prod_reg[20:0];
                mul_b = K100;
            end
            nrr_pkg::MUL_CD:
            begin
                mul_a = 21'(count_reg[ti]);
                mul_b = 20'(decay_pct);
            end
            nrr_pkg::MUL_CDB:
            begin
                mul_a = prod_reg[20:0];
                mul_b = 20'(base_reg[ti]);
            end
            nrr_pkg::MUL_V100:
            begin
                mul_a = prod_reg[20:0];
                mul_b = K100;
            end
            nrr_pkg::MUL_ACC:
            begin
                mul_a = 21'(vel6);
                mul_b = K5;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Non-tick command: decide the note-off it releases.
    always_comb
    begin
        cmd_emit = 1'b0;
        cmd_ev   = '0;
        cmd_ev.track_out = req_reg.track;
        case (req_reg.command)
            nrr_pkg::CMD_STOP:
            begin
                cmd_emit = in_range && active_reg[ri] && sounding_reg[ri]
                           && (note_reg[ri] == req_reg.note_in)
                           && (chan_reg[ri] == req_reg.channel_in);
                cmd_ev.note_out    = req_reg.note_in;
                cmd_ev.channel_out = req_reg.channel_in;
            end
            nrr_pkg::CMD_STOP_ALL:
            begin
                cmd_emit = in_range && active_reg[ri] && sounding_reg[ri];
                cmd_ev.note_out    = note_reg[ri];
                cmd_ev.channel_out = chan_reg[ri];
            end
            default: cmd_emit = 1'b0;
        endcase
    end

    always_comb
    begin
        ev_data = '0;
        ev_data.track_out   = cmd.trk;
        ev_data.note_out    = note_reg[ti];
        ev_data.channel_out = chan_reg[ti];
        ev_load = cmd.emit_off || cmd.emit_on;
        if (cmd.emit_on)
        begin
            ev_data.velocity_out = vel_reg;
            ev_data.is_note_on   = 1'b1;
        end
        if (cmd.cmd_exec)
        begin
            ev_load = cmd_emit;
            ev_data = cmd_ev;
        end
    end

    assign out_free = !out_valid_reg || evt_ready;

    assign sts.is_tick    = (req_reg.command == nrr_pkg::CMD_TICK);
    assign sts.live       = enable_reg[cmd.trk] && active_reg[ti];
    assign sts.off_due    = sounding_reg[ti] && (elapsed_reg >= 32'(gtime_reg));
    assign sts.on_due     = (elapsed_reg >= 32'(interval_reg));
    assign sts.can_push   = !pend_valid_reg || out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg  <= 9'd120;
            enable_reg <= '0;
            rate_reg   <= 24'h492492;
            gate_reg   <= 56'd28369131510995250;
            decay_reg  <= 48'd44678567731850;
            accent_reg <= 64'h0101010101010101;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nrr_pkg::REG_TEMPO:
                begin
                    if (cfg_data[8:0] < 9'd20)
                    begin
                        tempo_reg <= 9'd20;
                    end
                    else if (cfg_data[8:0] > 9'd300)
                    begin
                        tempo_reg <= 9'd300;
                    end
                    else
                    begin
                        tempo_reg <= cfg_data[8:0];
                    end
                end
                nrr_pkg::REG_ENABLE: enable_reg <= cfg_data[7:0];
                nrr_pkg::REG_RATE:   rate_reg   <= cfg_data[23:0];
                nrr_pkg::REG_GATE:   gate_reg   <= cfg_data[55:0];
                nrr_pkg::REG_DECAY:  decay_reg  <= cfg_data[47:0];
                nrr_pkg::REG_ACCENT: accent_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_reg <= req;
        end
        if (cmd.tick_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= 10'(tempo_reg))
            begin
                rem_reg <= rem_shift - 10'(tempo_reg);
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
        if (cmd.mul_op != nrr_pkg::MUL_NONE)
        begin
            prod_reg <= 41'(mul_a) * 41'(mul_b);
        end
        if (cmd.mul_op == nrr_pkg::MUL_DIV3)
        begin
            elapsed_reg <= ms_reg - last_reg[ti];
        end
        if (cmd.set_interval)
        begin
            interval_reg <= interval_sel;
        end
        if (cmd.set_gtime)
        begin
            gtime_reg <= amt;
        end
        if (cmd.set_vel)
        begin
            vel_reg <= (amt >= 15'(base_reg[ti])) ? 7'd1 : (base_reg[ti] - amt[6:0]);
        end
        if (cmd.set_accent && acc_hit)
        begin
            vel_reg <= (vacc > 8'd127) ? 7'd127 : vacc[6:0];
        end
        if (ev_load)
        begin
            pend_reg <= ev_data;
        end
        if (ev_load && pend_valid_reg)
        begin
            out_reg <= pend_reg;
        end
        else if (cmd.flush)
        begin
            // last_event is the low bit of the beat
            out_reg <= {pend_reg[$bits(nrr_pkg::evt_t)-1:1], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TRACKS; i++)
            begin
                active_reg[i]   <= 1'b0;
                sounding_reg[i] <= 1'b0;
                note_reg[i]     <= '0;
                base_reg[i]     <= '0;
                chan_reg[i]     <= '0;
                last_reg[i]     <= '0;
                count_reg[i]    <= '0;
            end
        end
        else
        begin
            if (cmd.tick_start)
            begin
                ms_reg <= ms_reg + 32'd1;
            end
            if ((ev_load && pend_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ev_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit_off)
            begin
                sounding_reg[ti] <= 1'b0;
            end
            if (cmd.emit_on)
            begin
                sounding_reg[ti] <= 1'b1;
                last_reg[ti]     <= ms_reg;
                count_reg[ti]    <= count_reg[ti] + 8'd1;
            end
            if (cmd.cmd_exec && in_range)
            begin
                case (req_reg.command)
                    nrr_pkg::CMD_TRIGGER:
                    begin
                        if (enable_reg[req_reg.track])
                        begin
                            active_reg[ri]   <= 1'b1;
                            sounding_reg[ri] <= 1'b0;
                            note_reg[ri]     <= req_reg.note_in;
                            base_reg[ri]     <= req_reg.velocity_in;
                            chan_reg[ri]     <= req_reg.channel_in;
                            last_reg[ri]     <= ms_reg;
                            count_reg[ri]    <= '0;
                        end
                    end
                    nrr_pkg::CMD_STOP:
                    begin
                        if (active_reg[ri] && (note_reg[ri] == req_reg.note_in)
                            && (chan_reg[ri] == req_reg.channel_in))
                        begin
                            active_reg[ri]   <= 1'b0;
                            sounding_reg[ri] <= 1'b0;
                        end
                    end
                    nrr_pkg::CMD_STOP_ALL:
                    begin
                        active_reg[ri]   <= 1'b0;
                        sounding_reg[ri] <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/note_repeat_ratchet_engine_core.sv =====
// Top level of the note repeat ratchet engine.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  req     | req_valid, req_ready, req        | in
//  evt     | evt_valid, evt_ready, evt        | out
//  cfg     | cfg_we, cfg_index, cfg_data      | in
//
// A stop, stop-all or trigger is dispatched and executed, then hands off its beat.
// A tick runs the tempo divider, then walks every track: an idle track is skipped and a
// live track runs the shared multiplier sequence.
// Reset clears all track state and loads the register defaults.
// A stalled evt side holds the walk only when both the output and pending beat are full.
module note_repeat_ratchet_engine_core #(
    parameter int TRACKS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  nrr_pkg::req_t req,
    output logic          evt_valid,
    input  logic          evt_ready,
    output nrr_pkg::evt_t evt,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    nrr_pkg::nrr_cmd_t cmd;
    nrr_pkg::nrr_sts_t sts;

    nrr_ctrl #(
        .TRACKS (TRACKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    nrr_dpath #(
        .TRACKS (TRACKS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
